>>> hw/rtl/lkvt_pkg.sv
// Package with the sizes, command codes and state type of the key/value table.
`timescale 1ns / 1ps

package lkvt_pkg;

	localparam int CAPACITY   = 256;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_BITS  = $clog2(CAPACITY);
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
	localparam int CMD_BITS   = 3;

	// The last code is unused: the table is left alone and the command fails.
	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT     = 3'd0,
		CMD_UPDATE     = 3'd1,
		CMD_INS_UPD    = 3'd2,
		CMD_ERASE      = 3'd3,
		CMD_CONTAINS   = 3'd4,
		CMD_GET_BY_KEY = 3'd5,
		CMD_GET_BY_SLOT = 3'd6,
		CMD_UNUSED     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_SLOT,
		ST_ERASE,
		ST_RESP
	} state_t;

endpackage

>>> hw/rtl/lkvt_req_if.sv
// Request channel of the key/value table: one command word per handshake.
`timescale 1ns / 1ps

interface lkvt_req_if import lkvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   command;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] new_value;
	logic [SLOT_BITS-1:0]  slot_index;

	modport source (output valid, command, lookup_key, new_value, slot_index, input ready);
	modport sink   (input valid, command, lookup_key, new_value, slot_index, output ready);
endinterface

>>> hw/rtl/lkvt_rsp_if.sv
// Response channel of the key/value table: one result word per handshake.
`timescale 1ns / 1ps

interface lkvt_rsp_if import lkvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  success;
	logic [KEY_BITS-1:0]   found_key;
	logic [VALUE_BITS-1:0] found_value;
	logic [COUNT_BITS-1:0] entry_count;
	logic                  table_empty;

	modport source (output valid, success, found_key, found_value, entry_count, table_empty,
		input ready);
	modport sink   (input valid, success, found_key, found_value, entry_count, table_empty,
		output ready);
endinterface

>>> hw/rtl/linear_key_value_table.sv
// Top level of the linear key/value table.
`timescale 1ns / 1ps

// Usage
// The table takes one command word at a time on req and returns exactly one result
// word on rsp. Entries sit packed in slots 0 to count-1 of a single RAM holding key
// and value side by side; keys are found by reading the slots one per cycle from
// slot 0 and stopping at the first match.
// A key command reads the slots in the scan state up to and including the match, or up
// to the entry count on a miss, then passes through the act and result states, with an
// erase state between them for an erase that moves the last entry. Get by slot, an unused
// command code and any key command on an empty table skip the scan. The one read port of
// the RAM sets the scan rate.
// Throughput: one command at a time; req.ready is high only when the table is idle.
// The result register holds a finished word while the receiver stalls, and the next
// command is accepted meanwhile; a later result waits until that word is taken.
// Reset clears the entry count and the valid flag of the result register; the RAM
// contents are left as they are and are never read before being written.
module linear_key_value_table import lkvt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	lkvt_req_if.sink  req,
	lkvt_rsp_if.source rsp
);

	state_t state_q, state_d;

	// Latched command word.
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] scan_q;
	logic                  rd_valid_s1;
	logic [COUNT_BITS-1:0] idx_s1;

	logic                  hit_q;
	logic [SLOT_BITS-1:0]  hit_slot_q;
	logic [KEY_BITS-1:0]   hit_key_q;
	logic [VALUE_BITS-1:0] hit_val_q;

	logic                  res_ok_q;
	logic [KEY_BITS-1:0]   res_key_q;
	logic [VALUE_BITS-1:0] res_val_q;

	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [KEY_BITS-1:0]   out_key_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_empty_q;

	// RAM controls.
	logic                  mem_we;
	logic [SLOT_BITS-1:0]  mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [SLOT_BITS-1:0]  mem_raddr;
	logic [ENTRY_BITS-1:0] mem_rdata;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	logic                  accept;
	logic                  scan_issue;
	logic                  scan_match;
	logic                  scan_last;
	logic [COUNT_BITS-1:0] last_idx;
	logic                  full;
	logic                  act_ok;
	logic [KEY_BITS-1:0]   act_key;
	logic [VALUE_BITS-1:0] act_val;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic                  load_out;

	assign rd_key   = mem_rdata[ENTRY_BITS-1:VALUE_BITS];
	assign rd_val   = mem_rdata[VALUE_BITS-1:0];
	assign accept   = req.valid && req.ready;
	assign last_idx = count_q - COUNT_BITS'(1);
	assign full     = (count_q == COUNT_BITS'(CAPACITY));
	assign load_out = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	assign scan_issue = (state_q == ST_SCAN) && (scan_q < count_q);
	assign scan_match = rd_valid_s1 && (rd_key == key_q);
	assign scan_last  = rd_valid_s1 && (idx_s1 == last_idx);

	assign req.ready = (state_q == ST_IDLE);

	lkvt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM controls and the outcome of the command. The state machine
	// never reads and writes the same slot in one cycle, so no forwarding is needed.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = hit_slot_q;
		mem_wdata = {key_q, val_q};
		mem_re    = 1'b0;
		mem_raddr = scan_q[SLOT_BITS-1:0];
		act_ok    = 1'b0;
		act_key   = '0;
		act_val   = '0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd_t'(req.command) == CMD_GET_BY_SLOT) begin
						if ({1'b0, req.slot_index} < count_q) begin
							mem_re    = 1'b1;
							mem_raddr = req.slot_index;
							state_d   = ST_SLOT;
						end else begin
							state_d = ST_ACT;
						end
					end else if (cmd_t'(req.command) == CMD_UNUSED || count_q == '0) begin
						state_d = ST_ACT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_re = scan_issue;
				if (scan_match || scan_last) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				state_d = ST_RESP;
				unique case (cmd_q) inside
					CMD_INSERT, CMD_INS_UPD: begin
						if (hit_q) begin
							if (cmd_q == CMD_INS_UPD) begin
								mem_we  = 1'b1;
								act_ok  = 1'b1;
								act_key = key_q;
								act_val = val_q;
							end
						end else if (!full) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[SLOT_BITS-1:0];
							cnt_inc   = 1'b1;
							act_ok    = 1'b1;
							act_key   = key_q;
							act_val   = val_q;
						end
					end
					CMD_UPDATE: begin
						if (hit_q) begin
							mem_we  = 1'b1;
							act_ok  = 1'b1;
							act_key = key_q;
							act_val = val_q;
						end
					end
					CMD_ERASE: begin
						if (hit_q) begin
							act_ok  = 1'b1;
							act_key = hit_key_q;
							act_val = hit_val_q;
							if ({1'b0, hit_slot_q} == last_idx) begin
								cnt_dec = 1'b1;
							end else begin
								// Fetch the last entry to fill the freed slot.
								mem_re    = 1'b1;
								mem_raddr = last_idx[SLOT_BITS-1:0];
								state_d   = ST_ERASE;
							end
						end
					end
					CMD_CONTAINS, CMD_GET_BY_KEY: begin
						if (hit_q) begin
							act_ok  = 1'b1;
							act_key = hit_key_q;
							act_val = hit_val_q;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SLOT: begin
				state_d = ST_RESP;
			end
			ST_ERASE: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				cnt_dec   = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + COUNT_BITS'(1);
			end else if (cnt_dec) begin
				count_q <= last_idx;
			end
			rd_valid_s1 <= scan_issue;
			if (accept) begin
				hit_q <= 1'b0;
			end else if (state_q == ST_SCAN && scan_match) begin
				hit_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(req.command);
			key_q  <= req.lookup_key;
			val_q  <= req.new_value;
			scan_q <= '0;
		end else if (scan_issue) begin
			scan_q <= scan_q + COUNT_BITS'(1);
		end
		idx_s1 <= scan_q;
		if (state_q == ST_SCAN && scan_match) begin
			hit_slot_q <= idx_s1[SLOT_BITS-1:0];
			hit_key_q  <= rd_key;
			hit_val_q  <= rd_val;
		end
		if (state_q == ST_ACT) begin
			res_ok_q  <= act_ok;
			res_key_q <= act_key;
			res_val_q <= act_val;
		end else if (state_q == ST_SLOT) begin
			res_ok_q  <= 1'b1;
			res_key_q <= rd_key;
			res_val_q <= rd_val;
		end
		if (load_out) begin
			out_ok_q    <= res_ok_q;
			out_key_q   <= res_key_q;
			out_val_q   <= res_val_q;
			out_count_q <= count_q;
			out_empty_q <= (count_q == '0);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = out_ok_q;
	assign rsp.found_key   = out_key_q;
	assign rsp.found_value = out_val_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.table_empty = out_empty_q;

endmodule

>>> hw/rtl/lkvt_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lkvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/lkvt_checker.sv
// Port-level assertions for the key/value table and the bind that attaches them.
`timescale 1ns / 1ps

module lkvt_checker import lkvt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_success,
	input logic [KEY_BITS-1:0]   rsp_found_key,
	input logic [VALUE_BITS-1:0] rsp_found_value,
	input logic [COUNT_BITS-1:0] rsp_entry_count,
	input logic                  rsp_table_empty
);

	// A stalled result word keeps its valid, its key, its value and its entry count.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_key)
			&& $stable(rsp_found_value) && $stable(rsp_entry_count))
		else $error("result word changed while stalled");

	// The table works on one command at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a command was in progress");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_table_empty == (rsp_entry_count == '0))
		else $error("empty flag disagrees with entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= COUNT_BITS'(CAPACITY))
		else $error("entry count beyond capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_success |-> rsp_found_key == '0 && rsp_found_value == '0)
		else $error("failed command returned a non-zero entry");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_success     (rsp.success),
	.rsp_found_key   (rsp.found_key),
	.rsp_found_value (rsp.found_value),
	.rsp_entry_count (rsp.entry_count),
	.rsp_table_empty (rsp.table_empty)
);
